@@ src/iar_pkg.sv @@
`timescale 1ns / 1ps
// iar_pkg: shared constants, register codes and size helpers for the
// inverse affine remap address generator. No dependencies.
package iar_pkg;

	localparam int MAX_DIM  = 4096;
	localparam int DIM_W    = $clog2(MAX_DIM) + 1;   // holds MAX_DIM itself
	localparam int COORD_W  = 12;
	localparam int FIELD_W  = 13;                    // one size field
	localparam int SUM_W    = 32;
	localparam int COEF_W   = 9;
	localparam int OFF_W    = 21;
	localparam int SIZE_W   = 2 * FIELD_W;
	localparam int CFG_W    = SIZE_W;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INV_A    = 3'd0,
		REG_INV_B    = 3'd1,
		REG_INV_C    = 3'd2,
		REG_INV_D    = 3'd3,
		REG_OFF_X    = 3'd4,
		REG_OFF_Y    = 3'd5,
		REG_SRC_SIZE = 3'd6,
		REG_DST_SIZE = 3'd7
	} cfg_reg_t;

	localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(8193);

	typedef logic [DIM_W-1:0] dim_t;
	typedef logic [SUM_W-1:0] sum_t;

	// zero counts as one, anything past MAX_DIM clamps
	function automatic dim_t dim_of(input logic [FIELD_W-1:0] f);
		dim_t d;
		if (f == '0)
			d = DIM_W'(1);
		else if ({{(32-FIELD_W){1'b0}}, f} > 32'(MAX_DIM))
			d = DIM_W'(MAX_DIM);
		else
			d = DIM_W'(f);
		return d;
	endfunction

	// non-negative and below the limit
	function automatic logic inside_lim(input sum_t s, input dim_t lim);
		return (s[SUM_W-1:DIM_W] == '0) && (s[DIM_W-1:0] < lim);
	endfunction

endpackage

@@ src/inverse_affine_remap_address_gen_top.sv @@
`timescale 1ns / 1ps
// Inverse affine remap address generator, nearest neighbour. One result beat
// per input beat, one beat per clock sustained while out_ready stays high.
// A restart beat emits destination pixel zero of a new frame; other beats
// step the raster walk. Source coordinates come from running sums updated
// by addition only: each beat costs one 32-bit add per axis plus a bounds
// compare, all done in the cycle the beat is accepted and held in the output
// register. Output valid rises in the cycle after input accept; the output
// register frees in the same cycle it is taken, so input and output may
// move every clock. Configuration must only be written while no beat is
// in flight. Depends on iar_pkg.
module inverse_affine_remap_address_gen_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [iar_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [iar_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            restart,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [iar_pkg::COORD_W-1:0]     dst_x,
	output logic [iar_pkg::COORD_W-1:0]     dst_y,
	output logic [iar_pkg::COORD_W-1:0]     src_x,
	output logic [iar_pkg::COORD_W-1:0]     src_y,
	output logic                            in_bounds,
	output logic                            frame_last
);
	import iar_pkg::*;

	logic signed [COEF_W-1:0] inv_a_q, inv_b_q, inv_c_q, inv_d_q;
	logic signed [OFF_W-1:0]  off_x_q, off_y_q;
	logic [SIZE_W-1:0]        src_size_q, dst_size_q;

	logic [COORD_W-1:0] col_q, row_q;
	sum_t sum_sx_q, sum_sy_q, rs_sx_q, rs_sy_q;

	logic out_valid_q;
	logic [COORD_W-1:0] dst_x_q, dst_y_q, src_x_q, src_y_q;
	logic in_bounds_q, frame_last_q;

	logic accept;
	dim_t dw, dh, sw, sh;
	sum_t off_x_ext, off_y_ext;
	logic [COORD_W-1:0] cur_col, cur_row;
	sum_t cur_sx, cur_sy, cur_rs_x, cur_rs_y;
	logic ok, row_end, frame_end;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign dw = dim_of(dst_size_q[FIELD_W-1:0]);
	assign dh = dim_of(dst_size_q[SIZE_W-1:FIELD_W]);
	assign sw = dim_of(src_size_q[FIELD_W-1:0]);
	assign sh = dim_of(src_size_q[SIZE_W-1:FIELD_W]);

	assign off_x_ext = SUM_W'(off_x_q);
	assign off_y_ext = SUM_W'(off_y_q);

	always_comb begin
		cur_col  = restart ? '0 : col_q;
		cur_row  = restart ? '0 : row_q;
		cur_sx   = restart ? off_x_ext : sum_sx_q;
		cur_sy   = restart ? off_y_ext : sum_sy_q;
		cur_rs_x = restart ? off_x_ext : rs_sx_q;
		cur_rs_y = restart ? off_y_ext : rs_sy_q;
		ok        = inside_lim(cur_sx, sw) && inside_lim(cur_sy, sh);
		row_end   = ({1'b0, cur_col} + DIM_W'(1)) >= dw;
		frame_end = row_end && (({1'b0, cur_row} + DIM_W'(1)) >= dh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_a_q    <= COEF_W'(1);
			inv_b_q    <= '0;
			inv_c_q    <= '0;
			inv_d_q    <= COEF_W'(1);
			off_x_q    <= '0;
			off_y_q    <= '0;
			src_size_q <= SIZE_RST;
			dst_size_q <= SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_INV_A:    inv_a_q    <= cfg_wdata[COEF_W-1:0];
				REG_INV_B:    inv_b_q    <= cfg_wdata[COEF_W-1:0];
				REG_INV_C:    inv_c_q    <= cfg_wdata[COEF_W-1:0];
				REG_INV_D:    inv_d_q    <= cfg_wdata[COEF_W-1:0];
				REG_OFF_X:    off_x_q    <= cfg_wdata[OFF_W-1:0];
				REG_OFF_Y:    off_y_q    <= cfg_wdata[OFF_W-1:0];
				REG_SRC_SIZE: src_size_q <= cfg_wdata[SIZE_W-1:0];
				REG_DST_SIZE: dst_size_q <= cfg_wdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			sum_sx_q <= '0;
			sum_sy_q <= '0;
			rs_sx_q  <= '0;
			rs_sy_q  <= '0;
		end else if (accept) begin
			if (!row_end) begin
				col_q    <= cur_col + COORD_W'(1);
				row_q    <= cur_row;
				sum_sx_q <= cur_sx + SUM_W'(inv_a_q);
				sum_sy_q <= cur_sy + SUM_W'(inv_c_q);
				rs_sx_q  <= cur_rs_x;
				rs_sy_q  <= cur_rs_y;
			end else if (!frame_end) begin
				col_q    <= '0;
				row_q    <= cur_row + COORD_W'(1);
				sum_sx_q <= cur_rs_x + SUM_W'(inv_b_q);
				sum_sy_q <= cur_rs_y + SUM_W'(inv_d_q);
				rs_sx_q  <= cur_rs_x + SUM_W'(inv_b_q);
				rs_sy_q  <= cur_rs_y + SUM_W'(inv_d_q);
			end else begin
				col_q    <= '0;
				row_q    <= '0;
				sum_sx_q <= off_x_ext;
				sum_sy_q <= off_y_ext;
				rs_sx_q  <= off_x_ext;
				rs_sy_q  <= off_y_ext;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			dst_x_q      <= cur_col;
			dst_y_q      <= cur_row;
			src_x_q      <= ok ? cur_sx[COORD_W-1:0] : '0;
			src_y_q      <= ok ? cur_sy[COORD_W-1:0] : '0;
			in_bounds_q  <= ok;
			frame_last_q <= frame_end;
		end
	end

	assign out_valid  = out_valid_q;
	assign dst_x      = dst_x_q;
	assign dst_y      = dst_y_q;
	assign src_x      = src_x_q;
	assign src_y      = src_y_q;
	assign in_bounds  = in_bounds_q;
	assign frame_last = frame_last_q;

	a_accept_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted beat produced no result");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	a_oob_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !in_bounds) |-> (src_x == '0 && src_y == '0))
		else $error("out-of-bounds beat carries a source coordinate");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(dst_x) && $stable(dst_y)))
		else $error("stalled result dropped or changed");

endmodule

@@ tb/iar_walk_checker.sv @@
`timescale 1ns / 1ps
// iar_walk_checker: watches the config port and both beat channels of the
// remap address generator, predicts each output beat and compares it.
// Depends on iar_pkg.
module iar_walk_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [iar_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [iar_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          restart,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [iar_pkg::COORD_W-1:0]   dst_x,
	input  logic [iar_pkg::COORD_W-1:0]   dst_y,
	input  logic [iar_pkg::COORD_W-1:0]   src_x,
	input  logic [iar_pkg::COORD_W-1:0]   src_y,
	input  logic                          in_bounds,
	input  logic                          frame_last,
	output int                            errors,
	output int                            pending
);
	import iar_pkg::*;

	typedef struct packed {
		logic [COORD_W-1:0] dx;
		logic [COORD_W-1:0] dy;
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
		logic               inb;
		logic               last;
	} pixel_t;

	pixel_t expected_px[$];
	int     fail_count = 0;
	int     backlog = 0;
	int     beat_no = 0;

	// register image, coefficients and offsets sign-extended to sum width
	sum_t              step_a, step_b, step_c, step_d, org_x, org_y;
	logic [SIZE_W-1:0] src_dims, dst_dims;

	// walk state
	int unsigned col_idx, row_idx;
	sum_t        walk_x, walk_y, line_x, line_y;

	assign errors  = fail_count;
	assign pending = backlog;

	function automatic int unsigned clamp_dim(input logic [FIELD_W-1:0] f);
		int unsigned d;
		if (f == '0)
			d = 1;
		else if (f > MAX_DIM)
			d = MAX_DIM;
		else
			d = 32'(f);
		return d;
	endfunction

	function automatic bit in_range(input sum_t s, input int unsigned lim);
		return (s[SUM_W-1] == 1'b0) && (s < lim);
	endfunction

	task automatic flag_error(input string msg);
		$display("%0t iar_check: beat %0d: %s", $time, beat_no, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [COORD_W-1:0] got,
			input logic [COORD_W-1:0] want);
		if (got !== want)
			flag_error($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	task automatic rewind();
		col_idx = 0;
		row_idx = 0;
		line_x  = org_x;
		line_y  = org_y;
		walk_x  = org_x;
		walk_y  = org_y;
	endtask

	task automatic map_pixel(input logic fresh);
		int unsigned dw, dh, sw, sh;
		bit          inb, row_end, frame_end;
		pixel_t      px;
		dw = clamp_dim(dst_dims[FIELD_W-1:0]);
		dh = clamp_dim(dst_dims[SIZE_W-1:FIELD_W]);
		sw = clamp_dim(src_dims[FIELD_W-1:0]);
		sh = clamp_dim(src_dims[SIZE_W-1:FIELD_W]);
		if (fresh)
			rewind();
		inb       = in_range(walk_x, sw) && in_range(walk_y, sh);
		row_end   = (col_idx + 1 >= dw);
		frame_end = row_end && (row_idx + 1 >= dh);
		px.dx   = col_idx[COORD_W-1:0];
		px.dy   = row_idx[COORD_W-1:0];
		px.sx   = inb ? walk_x[COORD_W-1:0] : '0;
		px.sy   = inb ? walk_y[COORD_W-1:0] : '0;
		px.inb  = inb;
		px.last = frame_end;
		expected_px.push_back(px);
		if (!row_end) begin
			col_idx++;
			walk_x += step_a;
			walk_y += step_c;
		end else if (!frame_end) begin
			col_idx = 0;
			row_idx++;
			line_x += step_b;
			line_y += step_d;
			walk_x  = line_x;
			walk_y  = line_y;
		end else begin
			rewind();
		end
	endtask

	task automatic check_pixel();
		pixel_t want;
		if (expected_px.size() == 0) begin
			flag_error("output beat with nothing expected");
		end else begin
			want = expected_px.pop_front();
			check_field("dst_x", dst_x, want.dx);
			check_field("dst_y", dst_y, want.dy);
			check_field("src_x", src_x, want.sx);
			check_field("src_y", src_y, want.sy);
			check_field("in_bounds", COORD_W'(in_bounds), COORD_W'(want.inb));
			check_field("frame_last", COORD_W'(frame_last), COORD_W'(want.last));
		end
		beat_no++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_a   = SUM_W'(1);
			step_b   = '0;
			step_c   = '0;
			step_d   = SUM_W'(1);
			org_x    = '0;
			org_y    = '0;
			src_dims = SIZE_RST;
			dst_dims = SIZE_RST;
			col_idx  = 0;
			row_idx  = 0;
			walk_x   = '0;
			walk_y   = '0;
			line_x   = '0;
			line_y   = '0;
			expected_px.delete();
			backlog <= 0;
		end else begin
			if (out_valid && out_ready)
				check_pixel();
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_idx))
					REG_INV_A:    step_a = {{(SUM_W-COEF_W){cfg_wdata[COEF_W-1]}},
							cfg_wdata[COEF_W-1:0]};
					REG_INV_B:    step_b = {{(SUM_W-COEF_W){cfg_wdata[COEF_W-1]}},
							cfg_wdata[COEF_W-1:0]};
					REG_INV_C:    step_c = {{(SUM_W-COEF_W){cfg_wdata[COEF_W-1]}},
							cfg_wdata[COEF_W-1:0]};
					REG_INV_D:    step_d = {{(SUM_W-COEF_W){cfg_wdata[COEF_W-1]}},
							cfg_wdata[COEF_W-1:0]};
					REG_OFF_X:    org_x = {{(SUM_W-OFF_W){cfg_wdata[OFF_W-1]}},
							cfg_wdata[OFF_W-1:0]};
					REG_OFF_Y:    org_y = {{(SUM_W-OFF_W){cfg_wdata[OFF_W-1]}},
							cfg_wdata[OFF_W-1:0]};
					REG_SRC_SIZE: src_dims = cfg_wdata[SIZE_W-1:0];
					REG_DST_SIZE: dst_dims = cfg_wdata[SIZE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				map_pixel(restart);
			// non-blocking so the stimulus side sees a settled count
			backlog <= expected_px.size();
		end
	end

endmodule

@@ tb/tb_inverse_affine_remap_address_gen_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the inverse affine remap address generator: clock, reset,
// config writes and pixel beats with random gaps and output stalls.
// Depends on iar_pkg, the block and iar_walk_checker.
module tb_inverse_affine_remap_address_gen_top;
	import iar_pkg::*;

	localparam int LIMIT  = 1_000_000;
	localparam int N_PIX  = 2000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 in_valid;
	logic                 in_ready;
	logic                 restart;
	logic                 out_valid;
	logic                 out_ready;
	logic [COORD_W-1:0]   dst_x, dst_y, src_x, src_y;
	logic                 in_bounds;
	logic                 frame_last;

	int fails;
	int in_flight;
	int cycles = 0;
	bit in_calm = 1'b0;
	bit out_calm = 1'b0;

	inverse_affine_remap_address_gen_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.dst_x      (dst_x),
		.dst_y      (dst_y),
		.src_x      (src_x),
		.src_y      (src_y),
		.in_bounds  (in_bounds),
		.frame_last (frame_last)
	);

	iar_walk_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.dst_x      (dst_x),
		.dst_y      (dst_y),
		.src_x      (src_x),
		.src_y      (src_y),
		.in_bounds  (in_bounds),
		.frame_last (frame_last),
		.errors     (fails),
		.pending    (in_flight)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb_inverse_affine_remap_address_gen_top: done, errors");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [CFG_W-1:0] pack_dims(input logic [FIELD_W-1:0] w,
			input logic [FIELD_W-1:0] h);
		return {h, w};
	endfunction

	function automatic int rand_coef();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return int'($urandom_range(0, 6)) - 3;
		if (r < 7)
			return int'($urandom());   // junk above bit 8 is ignored
		if (r == 7)
			return -256;
		if (r == 8)
			return 255;
		return int'($urandom_range(0, 1));
	endfunction

	function automatic int rand_off();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return int'($urandom_range(0, 48)) - 8;
		if (r < 8)
			return int'($urandom());
		if (r == 8)
			return -1048576;
		return 1048575;
	endfunction

	function automatic logic [FIELD_W-1:0] rand_src_field();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return FIELD_W'($urandom_range(1, 48));
		if (r == 7)
			return '0;
		if (r == 8)
			return FIELD_W'($urandom_range(MAX_DIM, 8191));
		return FIELD_W'($urandom());
	endfunction

	// frames kept small so that wraps are frequent
	function automatic logic [FIELD_W-1:0] rand_dst_field();
		int r;
		r = $urandom_range(0, 19);
		if (r < 16)
			return FIELD_W'($urandom_range(1, 12));
		if (r < 18)
			return FIELD_W'($urandom_range(13, 40));
		case ($urandom_range(0, 3))
			0: return '0;
			1: return FIELD_W'(MAX_DIM);
			2: return '1;
			default: return FIELD_W'($urandom());
		endcase
	endfunction

	task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_idx   <= r;
		cfg_wdata <= v;
		@(posedge clk);
	endtask

	task automatic set_regs(input int a, input int b, input int c, input int d,
			input int ox, input int oy, input logic [CFG_W-1:0] ssz,
			input logic [CFG_W-1:0] dsz);
		write_reg(REG_INV_A, CFG_W'(a));
		write_reg(REG_INV_B, CFG_W'(b));
		write_reg(REG_INV_C, CFG_W'(c));
		write_reg(REG_INV_D, CFG_W'(d));
		write_reg(REG_OFF_X, CFG_W'(ox));
		write_reg(REG_OFF_Y, CFG_W'(oy));
		write_reg(REG_SRC_SIZE, ssz);
		write_reg(REG_DST_SIZE, dsz);
		cfg_we <= 1'b0;
	endtask

	task automatic send_pixel(input logic fresh);
		int gap;
		in_valid <= 1'b1;
		restart  <= fresh;
		do
			@(posedge clk);
		while (!in_ready);
		gap = in_calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drain every outstanding beat, then a few spare clocks for the pipe
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (in_flight != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin : stall_loop
			int gap;
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			gap = out_calm ? 0 : pick_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int total;
		int n;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_idx   <= REG_INV_A;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		restart   <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// walk from reset with no restart: sums start at zero, the offsets
		// only come in at the frame wrap
		set_regs(1, 0, 0, 1, 5, 3, pack_dims(4, 4), pack_dims(3, 2));
		repeat (7) send_pixel(1'b0);
		settle();

		// coefficient and offset extremes, zero and oversized size fields
		set_regs(-256, 255, 255, -256, -1048576, 1048575, pack_dims(0, 8191),
			pack_dims(8191, 0));
		send_pixel(1'b1);
		repeat (3) send_pixel(1'b0);
		settle();

		// source corner at its largest coordinate, then stepping off it
		set_regs(255, -256, -256, 255, 4095, 4095, pack_dims(MAX_DIM, MAX_DIM),
			pack_dims(2, 2));
		send_pixel(1'b1);
		repeat (4) send_pixel(1'b0);
		settle();

		// shrink the destination mid-frame: the current column ends the row
		// and the current row ends the frame
		set_regs(1, 0, 0, 1, 0, 0, pack_dims(8, 8), pack_dims(6, 4));
		send_pixel(1'b1);
		repeat (7) send_pixel(1'b0);
		settle();
		write_reg(REG_DST_SIZE, pack_dims(2, 1));
		cfg_we <= 1'b0;
		repeat (2) send_pixel(1'b0);
		settle();

		// random settings; a phase may carry on the walk under new settings
		total = 0;
		while (total < N_PIX) begin
			in_calm  = ($urandom_range(0, 3) == 0);
			out_calm = ($urandom_range(0, 3) == 0);
			set_regs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_off(),
				rand_off(), pack_dims(rand_src_field(), rand_src_field()),
				pack_dims(rand_dst_field(), rand_dst_field()));
			n = $urandom_range(60, 140);
			for (int k = 0; k < n; k++) begin
				if (k == 0)
					send_pixel($urandom_range(0, 9) < 7);
				else
					send_pixel($urandom_range(0, 24) == 0);
			end
			total += n;
			settle();
		end

		if (fails == 0)
			$display("tb_inverse_affine_remap_address_gen_top: done, clean");
		else
			$display("tb_inverse_affine_remap_address_gen_top: done, errors");
		$finish;
	end

endmodule

@@ inverse_affine_remap_address_gen_top.f @@
src/iar_pkg.sv
src/inverse_affine_remap_address_gen_top.sv
tb/iar_walk_checker.sv
tb/tb_inverse_affine_remap_address_gen_top.sv
